// ===== hw/rtl/xor_checked_command_frame_parser_assert.svh =====
// Assertion macros shared by the frame parser RTL.
// XCFP_ASSERT_RST: checked on rising clk, skipped while rst is high.
// XCFP_ASSERT_ALL: checked on rising clk, also during reset.
`ifndef XOR_CHECKED_COMMAND_FRAME_PARSER_ASSERT_SVH
`define XOR_CHECKED_COMMAND_FRAME_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
`define XCFP_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("frame parser assertion failed");
`define XCFP_ASSERT_ALL(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("frame parser assertion failed");
`else
`define XCFP_ASSERT_RST(label, prop)
`define XCFP_ASSERT_ALL(label, prop)
`endif

`endif

// ===== hw/rtl/xcfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package xcfp_pkg;

  localparam int BYTE_W = 8;
  localparam int CMD_W  = 3;
  localparam int LEN_W  = 4;
  localparam int APB_DW = 32;
  localparam int APB_AW = 5;

endpackage
`default_nettype wire

// ===== hw/rtl/xcfp_rx_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface xcfp_rx_if;
  logic                       valid;
  logic                       ready;
  logic [xcfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/xcfp_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface xcfp_res_if;
  logic                        valid;
  logic                        ready;
  logic [xcfp_pkg::CMD_W-1:0]  command;
  logic [xcfp_pkg::LEN_W-1:0]  payload_length;
  logic [xcfp_pkg::LEN_W-1:0]  byte_index;
  logic [xcfp_pkg::BYTE_W-1:0] payload_byte;
  logic                        last;

  modport source (output valid, output command, output payload_length,
                  output byte_index, output payload_byte, output last,
                  input ready);
  modport sink (input valid, input command, input payload_length,
                input byte_index, input payload_byte, input last,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/xor_checked_command_frame_parser.sv =====
// Command frame parser with XOR check. Bytes arrive on rx, one transaction per
// byte; frames are header_first, header_second, command, length (0..MAX_PAYLOAD),
// payload, XOR of command/length/payload, trailer_first, trailer_second. Any
// mismatch drops back to hunting for header_first without re-examining the byte.
// Rate: while parsing, one byte is taken every cycle. When a frame completes,
// rx is held off and the frame goes out on res as one transaction per payload
// byte (a single zero-data transaction for an empty frame). Each result takes
// three steps (payload store read, output load, handshake), the handshake held
// while the sink stalls, and rx stays blocked until the last one is taken. The
// payload is held in a MAX_PAYLOAD x 8 single-port synchronous memory; no clear
// pass is needed since entries are only read after being written in the same
// frame. Registers sit on the APB port at byte address 4*i: header_first,
// header_second, trailer_first, trailer_second, command_enable_mask.
`timescale 1ns / 1ps
`default_nettype none
`include "xor_checked_command_frame_parser_assert.svh"
module xor_checked_command_frame_parser #(
  parameter int MAX_PAYLOAD = 9
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  xcfp_rx_if.sink                            rx,
  xcfp_res_if.source                         res,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [xcfp_pkg::APB_AW-1:0]   paddr,
  input  wire logic [xcfp_pkg::APB_DW-1:0]   pwdata,
  output logic      [xcfp_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);

  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int BW = xcfp_pkg::BYTE_W;

  localparam logic [2:0] PH_HUNT1 = 3'd0;
  localparam logic [2:0] PH_HUNT2 = 3'd1;
  localparam logic [2:0] PH_CMD   = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CHECK = 3'd5;
  localparam logic [2:0] PH_END1  = 3'd6;
  localparam logic [2:0] PH_END2  = 3'd7;

  localparam logic [1:0] M_PARSE = 2'd0;
  localparam logic [1:0] M_READ  = 2'd1;
  localparam logic [1:0] M_LOAD  = 2'd2;
  localparam logic [1:0] M_HOLD  = 2'd3;

  localparam logic [2:0] REG_HDR1 = 3'd0;
  localparam logic [2:0] REG_HDR2 = 3'd1;
  localparam logic [2:0] REG_TRL1 = 3'd2;
  localparam logic [2:0] REG_TRL2 = 3'd3;
  localparam logic [2:0] REG_MASK = 3'd4;

  logic [BW-1:0] header_first, header_second, trailer_first, trailer_second;
  logic [BW-1:0] command_enable_mask;

  logic [2:0]    phase;
  logic [1:0]    mode;
  logic [xcfp_pkg::CMD_W-1:0] held_cmd;
  logic [CW-1:0] held_len;
  logic [CW-1:0] cnt;
  logic [CW-1:0] rd_idx;
  logic [BW-1:0] check;
  logic          out_valid;
  logic [BW-1:0] out_byte;
  logic          out_last;

  logic [BW-1:0] store [MAX_PAYLOAD];
  logic [BW-1:0] rd_data;

  logic          in_fire;
  logic          cfg_wr;
  logic [2:0]    reg_sel;
  logic [BW-1:0] b;
  logic          mem_we;
  logic          mem_re;
  logic          idx_last;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign reg_sel  = paddr[4:2];
  assign rx.ready = (mode == M_PARSE);
  assign in_fire  = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign mem_we   = in_fire && (phase == PH_DATA) && (cnt < held_len);
  assign mem_re   = (mode == M_READ);
  assign idx_last = ((CW+1)'(rd_idx) + (CW+1)'(1)) == (CW+1)'(held_len);

  assign res.valid          = out_valid;
  assign res.command        = held_cmd;
  assign res.payload_length = xcfp_pkg::LEN_W'(held_len);
  assign res.byte_index     = xcfp_pkg::LEN_W'(rd_idx);
  assign res.payload_byte   = out_byte;
  assign res.last           = out_last;

  always_comb begin
    unique case (reg_sel)
      REG_HDR1: prdata = xcfp_pkg::APB_DW'(header_first);
      REG_HDR2: prdata = xcfp_pkg::APB_DW'(header_second);
      REG_TRL1: prdata = xcfp_pkg::APB_DW'(trailer_first);
      REG_TRL2: prdata = xcfp_pkg::APB_DW'(trailer_second);
      REG_MASK: prdata = xcfp_pkg::APB_DW'(command_enable_mask);
      default:  prdata = '0;
    endcase
  end

  // payload store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[AW'(cnt)] <= b;
    end
    if (mem_re) begin
      rd_data <= store[AW'(rd_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first        <= 8'd170;
      header_second       <= 8'd85;
      trailer_first       <= 8'd13;
      trailer_second      <= 8'd10;
      command_enable_mask <= 8'd254;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_HDR1: header_first        <= pwdata[BW-1:0];
        REG_HDR2: header_second       <= pwdata[BW-1:0];
        REG_TRL1: trailer_first       <= pwdata[BW-1:0];
        REG_TRL2: trailer_second      <= pwdata[BW-1:0];
        REG_MASK: command_enable_mask <= pwdata[BW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT1;
      mode      <= M_PARSE;
      held_cmd  <= '0;
      held_len  <= '0;
      cnt       <= '0;
      rd_idx    <= '0;
      check     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (mode)
        M_PARSE: begin
          if (in_fire) begin
            unique case (phase)
              PH_HUNT1: phase <= (b == header_first) ? PH_HUNT2 : PH_HUNT1;
              PH_HUNT2: begin
                if (b == header_second) begin
                  cnt   <= '0;
                  check <= '0;
                  phase <= PH_CMD;
                end else begin
                  phase <= PH_HUNT1;
                end
              end
              PH_CMD: begin
                if (b[BW-1:3] == '0 && command_enable_mask[b[2:0]]) begin
                  held_cmd <= b[2:0];
                  check    <= check ^ b;
                  phase    <= PH_LEN;
                end else begin
                  phase <= PH_HUNT1;
                end
              end
              PH_LEN: begin
                if (b <= BW'(MAX_PAYLOAD)) begin
                  held_len <= CW'(b);
                  check    <= check ^ b;
                  cnt      <= '0;
                  phase    <= (b == '0) ? PH_CHECK : PH_DATA;
                end else begin
                  phase <= PH_HUNT1;
                end
              end
              PH_DATA: begin
                // held_len >= 1 here, so every data byte is stored
                check <= check ^ b;
                if ((CW+1)'(cnt) + (CW+1)'(1) >= (CW+1)'(held_len)) begin
                  cnt   <= '0;
                  phase <= PH_CHECK;
                end else begin
                  cnt <= cnt + CW'(1);
                end
              end
              PH_CHECK: phase <= (b == check) ? PH_END1 : PH_HUNT1;
              PH_END1:  phase <= (b == trailer_first) ? PH_END2 : PH_HUNT1;
              PH_END2: begin
                phase <= PH_HUNT1;
                if (b == trailer_second) begin
                  rd_idx <= '0;
                  if (held_len == '0) begin
                    out_byte  <= '0;
                    out_last  <= 1'b1;
                    out_valid <= 1'b1;
                    mode      <= M_HOLD;
                  end else begin
                    mode <= M_READ;
                  end
                end
              end
              default: phase <= PH_HUNT1;
            endcase
          end
        end
        M_READ: mode <= M_LOAD;
        M_LOAD: begin
          out_byte  <= rd_data;
          out_last  <= idx_last;
          out_valid <= 1'b1;
          mode      <= M_HOLD;
        end
        M_HOLD: begin
          if (res.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              mode <= M_PARSE;
            end else begin
              rd_idx <= rd_idx + CW'(1);
              mode   <= M_READ;
            end
          end
        end
        default: mode <= M_PARSE;
      endcase
    end
  end

  // rx and res never overlap
  `XCFP_ASSERT_ALL(a_rx_res_excl, rx.ready |-> !res.valid)
  // the store is written only from accepted data bytes
  `XCFP_ASSERT_RST(a_we_data, mem_we |-> (phase == PH_DATA && in_fire))
  // parser is back at frame hunt whenever a result is shown
  `XCFP_ASSERT_RST(a_emit_hunt, res.valid |-> (phase == PH_HUNT1))
  // a non-final result keeps rx closed; a final one reopens it
  `XCFP_ASSERT_RST(a_more_closed, (res.valid && res.ready && !res.last) |=> !rx.ready)
  `XCFP_ASSERT_RST(a_last_open, (res.valid && res.ready && res.last) |=> rx.ready)

endmodule
`default_nettype wire
